[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the fraction arithmetic block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define CHECK_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define CHECK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/rar_pkg.sv]
// ----------------------------------------------------------------------------
// rar_pkg
// field widths and operation codes of the fraction arithmetic block
// ----------------------------------------------------------------------------
`default_nettype none

package rar_pkg;

  localparam int KIND_BITS = 3;
  localparam int IN_BITS   = 31;
  localparam int OUT_BITS  = 62;

  localparam logic [KIND_BITS-1:0] KIND_ADD    = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_SUB    = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_MUL    = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_DIV    = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_REDUCE = 3'd4;

endpackage

`default_nettype wire

[rtl/rar_req_if.sv]
// ----------------------------------------------------------------------------
// rar_req_if
// request channel: operation code and two signed fractions
// ----------------------------------------------------------------------------
`default_nettype none

interface rar_req_if;
  import rar_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [KIND_BITS-1:0]       kind;
  logic signed [IN_BITS-1:0]  num_a;
  logic signed [IN_BITS-1:0]  den_a;
  logic signed [IN_BITS-1:0]  num_b;
  logic signed [IN_BITS-1:0]  den_b;

  modport source (output valid, kind, num_a, den_a, num_b, den_b, input ready);
  modport sink   (input valid, kind, num_a, den_a, num_b, den_b, output ready);
endinterface

`default_nettype wire

[rtl/rar_res_if.sv]
// ----------------------------------------------------------------------------
// rar_res_if
// result channel: sign flag, whole part and reduced proper fraction
// ----------------------------------------------------------------------------
`default_nettype none

interface rar_res_if;
  import rar_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 divide_by_zero;
  logic                 negative;
  logic [OUT_BITS-1:0]  whole_part;
  logic [OUT_BITS-1:0]  frac_numerator;
  logic [OUT_BITS-1:0]  frac_denominator;

  modport source (output valid, divide_by_zero, negative, whole_part, frac_numerator,
                  frac_denominator, input ready);
  modport sink   (input valid, divide_by_zero, negative, whole_part, frac_numerator,
                  frac_denominator, output ready);
endinterface

`default_nettype wire

[rtl/rational_arith_reduce_top.sv]
// Fraction arithmetic with gcd reduction. A request carries two signed
// fractions and an operation (add, subtract, multiply, divide, or reduce the
// first fraction); the block answers with the reduced result as a sign flag,
// a whole part and a proper fraction, all magnitudes, or with divide_by_zero
// set and the other fields zero. Only the low OPERAND_BITS bits of each
// operand count. One request is worked on at a time: three products through a
// shared signed multiplier, a combine step, a magnitude step, a binary gcd,
// then three divisions through one shared restoring divider. A request whose
// denominator is zero finishes at the combine step. A finished result sits
// in the output register until taken; the next request is accepted
// meanwhile, but its result waits for that register to free.
// ----------------------------------------------------------------------------
// rational_arith_reduce_top
// sequencer, shared multiplier and result register of the fraction unit
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rational_arith_reduce_top #(
  parameter int OPERAND_BITS = 31
) (
  input  logic      clk,
  input  logic      rst,
  rar_req_if.sink   req,
  rar_res_if.source res
);
  import rar_pkg::*;

  localparam int W  = OPERAND_BITS;
  localparam int PW = 2 * OPERAND_BITS;
  localparam int NW = PW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_COMB, S_MAG, S_GCD, S_DIV_N, S_DIV_D, S_DIV_W
  } state_t;

  state_t               state;
  logic                 done_pend;
  logic [1:0]           step;
  logic [KIND_BITS-1:0] op_kind;
  logic signed [W-1:0]  op_a;
  logic signed [W-1:0]  op_da;
  logic signed [W-1:0]  op_b;
  logic signed [W-1:0]  op_db;
  logic signed [W-1:0]  mul_x;
  logic signed [W-1:0]  mul_y;
  logic signed [PW-1:0] product;
  logic signed [PW-1:0] p_nx;
  logic signed [PW-1:0] p_ny;
  logic signed [PW-1:0] p_d;
  logic signed [NW-1:0] n_next;
  logic signed [PW-1:0] d_next;
  logic signed [NW-1:0] n_val;
  logic signed [PW-1:0] d_val;
  logic [NW-1:0]        n_abs;
  logic [PW-1:0]        d_abs;
  logic [PW-1:0]        mag_n;
  logic [PW-1:0]        mag_d;
  logic [PW-1:0]        whole;
  logic [PW-1:0]        rem;
  logic                 res_dbz;
  logic                 res_neg;
  logic                 gcd_start;
  logic                 gcd_done;
  logic [PW-1:0]        gcd_val;
  logic                 div_start;
  logic                 div_done;
  logic [PW-1:0]        div_x;
  logic [PW-1:0]        div_y;
  logic [PW-1:0]        div_q;
  logic [PW-1:0]        div_r;

  assign req.ready = (state == S_IDLE) && !done_pend;

  // operand selection for the shared multiplier
  always_comb begin
    case (step)
      2'd0: begin
        mul_x = op_a;
        mul_y = (op_kind == KIND_MUL) ? op_b : op_db;
      end
      2'd1: begin
        mul_x = op_b;
        mul_y = op_da;
      end
      default: begin
        mul_x = op_da;
        mul_y = (op_kind == KIND_DIV) ? op_b : op_db;
      end
    endcase
  end

  assign product = mul_x * mul_y;

  always_comb begin
    case (op_kind)
      KIND_ADD: begin
        n_next = NW'(p_nx) + NW'(p_ny);
        d_next = p_d;
      end
      KIND_SUB: begin
        n_next = NW'(p_nx) - NW'(p_ny);
        d_next = p_d;
      end
      KIND_MUL, KIND_DIV: begin
        n_next = NW'(p_nx);
        d_next = p_d;
      end
      default: begin
        // reduce, and the unused codes
        n_next = NW'(op_a);
        d_next = PW'(op_da);
      end
    endcase
  end

  assign n_abs = n_val[NW-1] ? -n_val : n_val;
  assign d_abs = d_val[PW-1] ? -d_val : d_val;

  rar_gcd #(.WIDTH(PW)) u_gcd (
    .clk    (clk),
    .rst    (rst),
    .start  (gcd_start),
    .x      (mag_n),
    .y      (mag_d),
    .done   (gcd_done),
    .result (gcd_val)
  );

  rar_divider #(.WIDTH(PW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_x),
    .divisor   (div_y),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done_pend <= 1'b0;
      gcd_start <= 1'b0;
      div_start <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      gcd_start <= 1'b0;
      div_start <= 1'b0;
      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      // hand a finished request to the output register once it is free
      if (done_pend && (!res.valid || res.ready)) begin
        res.valid            <= 1'b1;
        res.divide_by_zero   <= res_dbz;
        res.negative         <= res_neg;
        res.whole_part       <= OUT_BITS'(whole);
        res.frac_numerator   <= OUT_BITS'(rem);
        res.frac_denominator <= OUT_BITS'(mag_d);
        done_pend            <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid && !done_pend) begin
            op_kind <= req.kind;
            op_a    <= req.num_a[W-1:0];
            op_da   <= req.den_a[W-1:0];
            op_b    <= req.num_b[W-1:0];
            op_db   <= req.den_b[W-1:0];
            step    <= 2'd0;
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          case (step)
            2'd0:    p_nx <= product;
            2'd1:    p_ny <= product;
            default: p_d  <= product;
          endcase
          if (step == 2'd2) begin
            state <= S_COMB;
          end else begin
            step <= step + 2'd1;
          end
        end
        S_COMB: begin
          n_val <= n_next;
          d_val <= d_next;
          if (d_next == '0) begin
            res_dbz   <= 1'b1;
            res_neg   <= 1'b0;
            whole     <= '0;
            rem       <= '0;
            mag_d     <= '0;
            done_pend <= 1'b1;
            state     <= S_IDLE;
          end else begin
            res_dbz <= 1'b0;
            state   <= S_MAG;
          end
        end
        S_MAG: begin
          mag_n     <= n_abs[PW-1:0];
          mag_d     <= d_abs;
          res_neg   <= (n_val != '0) && (n_val[NW-1] != d_val[PW-1]);
          gcd_start <= 1'b1;
          state     <= S_GCD;
        end
        S_GCD: begin
          if (gcd_done) begin
            div_x     <= mag_n;
            div_y     <= gcd_val;
            div_start <= 1'b1;
            state     <= S_DIV_N;
          end
        end
        S_DIV_N: begin
          if (div_done) begin
            mag_n     <= div_q;
            div_x     <= mag_d;
            div_start <= 1'b1;
            state     <= S_DIV_D;
          end
        end
        S_DIV_D: begin
          if (div_done) begin
            mag_d     <= div_q;
            div_x     <= mag_n;
            div_y     <= div_q;
            div_start <= 1'b1;
            state     <= S_DIV_W;
          end
        end
        S_DIV_W: begin
          if (div_done) begin
            whole     <= div_q;
            rem       <= div_r;
            done_pend <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHECK_IMPL(a_dbz_clear, clk, rst, res.valid && res.divide_by_zero,
    !res.negative && res.whole_part == '0 && res.frac_denominator == '0)
  `CHECK_IMPL(a_proper, clk, rst, res.valid && !res.divide_by_zero,
    res.frac_numerator < res.frac_denominator)
  `CHECK_IMPL(a_zero_pos, clk, rst,
    res.valid && res.whole_part == '0 && res.frac_numerator == '0, !res.negative)

endmodule

`default_nettype wire

[rtl/rar_divider.sv]
// ----------------------------------------------------------------------------
// rar_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rar_divider #(
  parameter int WIDTH = 62
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic             busy;
  logic [CW-1:0]    count;
  logic [WIDTH-1:0] dvs;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;

  // quotient register doubles as the dividend shift line
  assign trial = {remainder, quotient[WIDTH-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        count     <= CW'(WIDTH - 1);
        quotient  <= dividend;
        remainder <= '0;
        dvs       <= divisor;
      end else if (busy) begin
        if (diff[WIDTH]) begin
          remainder <= trial[WIDTH-1:0];
        end else begin
          remainder <= diff[WIDTH-1:0];
        end
        quotient <= {quotient[WIDTH-2:0], ~diff[WIDTH]};
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 1'b1;
        end
      end
    end
  end

  `CHECK_IMPL(a_div_nonzero, clk, rst, start, divisor != '0)
  `CHECK_NEXT(a_div_busy, clk, rst, start, busy && !done)

endmodule

`default_nettype wire

[rtl/rar_gcd.sv]
// ----------------------------------------------------------------------------
// rar_gcd
// binary gcd with one shift or subtract per cycle
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rar_gcd #(
  parameter int WIDTH = 62
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  output logic             done,
  output logic [WIDTH-1:0] result
);

  localparam int KW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  typedef enum logic [1:0] {G_IDLE, G_RUN, G_RESTORE} gcd_state_t;

  gcd_state_t       state;
  logic [WIDTH-1:0] u;
  logic [WIDTH-1:0] v;
  logic [KW-1:0]    k;
  logic [WIDTH:0]   diff_uv;
  logic [WIDTH:0]   diff_vu;

  assign diff_uv = {1'b0, u} - {1'b0, v};
  assign diff_vu = {1'b0, v} - {1'b0, u};
  assign result  = v;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        G_IDLE: begin
          if (start) begin
            u     <= x;
            v     <= y;
            k     <= '0;
            state <= G_RUN;
          end
        end
        G_RUN: begin
          if (u == '0) begin
            state <= G_RESTORE;
          end else if (!u[0] && !v[0]) begin
            // common factor of two
            u <= u >> 1;
            v <= v >> 1;
            k <= k + 1'b1;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (!diff_uv[WIDTH]) begin
            u <= {1'b0, diff_uv[WIDTH-1:1]};
          end else begin
            v <= {1'b0, diff_vu[WIDTH-1:1]};
          end
        end
        G_RESTORE: begin
          // put the common powers of two back
          if (k == '0) begin
            done  <= 1'b1;
            state <= G_IDLE;
          end else begin
            v <= v << 1;
            k <= k - 1'b1;
          end
        end
        default: state <= G_IDLE;
      endcase
    end
  end

  `CHECK_IMPL(a_gcd_nonzero, clk, rst, done, result != '0)

endmodule

`default_nettype wire

[tb/sv/rational_arith_reduce_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arith_reduce_top_tb
// self-checking bench for the fraction arithmetic unit: a short list of
// directed requests (zero denominators, zero results, operand extremes, every
// operation and the spare codes), then random requests with random gaps on
// both channels, each result checked against a typed answer or a fraction predictor
// ----------------------------------------------------------------------------

module rational_arith_reduce_top_tb;
  import rar_pkg::*;

  localparam int          RANDOM_REQUESTS = 1500;
  localparam int          DRAIN_CYCLES    = 500;
  localparam int          CYCLE_LIMIT     = 4_000_000;
  localparam int          MAX_REPORTS     = 10;
  localparam int          OPER_MAX        = 1073741823;
  localparam int          OPER_MIN        = -1073741824;
  localparam logic [61:0] TWO_POW_30      = 62'd1073741824;
  localparam logic [61:0] TWO_POW_60      = 62'h1000_0000_0000_0000;

  // codes the block does not define, handled as reduce
  localparam logic [KIND_BITS-1:0] KIND_SPARE5 = 3'd5;
  localparam logic [KIND_BITS-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [KIND_BITS-1:0] KIND_SPARE7 = 3'd7;

  typedef struct packed {
    logic                dbz;
    logic                neg;
    logic [OUT_BITS-1:0] whole;
    logic [OUT_BITS-1:0] fnum;
    logic [OUT_BITS-1:0] fden;
  } answer_t;

  typedef struct {
    logic [KIND_BITS-1:0]      kind;
    logic signed [IN_BITS-1:0] na, da, nb, db;
    bit                        typed;
    answer_t                   ans;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rar_req_if req ();
  rar_res_if res ();

  rational_arith_reduce_top uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  request_t directed_requests[$];
  answer_t  pending_answers[$];
  bit       held_typed  = 1'b0;
  answer_t  held_answer = '0;
  bit       no_idle     = 1'b0;
  int       mismatch_count = 0;
  int       cycle_count    = 0;

  // exact fraction result: wide cross products, euclid gcd, whole part split
  function automatic answer_t fraction_result(logic [KIND_BITS-1:0] kind,
                                              logic signed [IN_BITS-1:0] a_n,
                                              logic signed [IN_BITS-1:0] a_d,
                                              logic signed [IN_BITS-1:0] b_n,
                                              logic signed [IN_BITS-1:0] b_d);
    longint          an, ad, bn, bd, num, den;
    longint unsigned mn, md, x, y, r;
    answer_t         ans;
    an  = longint'(a_n);
    ad  = longint'(a_d);
    bn  = longint'(b_n);
    bd  = longint'(b_d);
    ans = '0;
    case (kind)
      KIND_ADD: begin
        num = an * bd + bn * ad;
        den = ad * bd;
      end
      KIND_SUB: begin
        num = an * bd - bn * ad;
        den = ad * bd;
      end
      KIND_MUL: begin
        num = an * bn;
        den = ad * bd;
      end
      KIND_DIV: begin
        num = an * bd;
        den = ad * bn;
      end
      default: begin
        num = an;
        den = ad;
      end
    endcase
    if (den == 0) begin
      ans.dbz = 1'b1;
      return ans;
    end
    mn = (num < 0) ? -num : num;
    md = (den < 0) ? -den : den;
    x  = mn;
    y  = md;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    mn        = mn / x;
    md        = md / x;
    ans.whole = OUT_BITS'(mn / md);
    ans.fnum  = OUT_BITS'(mn % md);
    ans.fden  = OUT_BITS'(md);
    ans.neg   = (num != 0) && ((num < 0) != (den < 0));
    return ans;
  endfunction

  task automatic add_case(input logic [KIND_BITS-1:0] k, input int na, input int da,
                          input int nb, input int db, input bit typed = 1'b0,
                          input bit dbz = 1'b0, input bit neg = 1'b0,
                          input logic [61:0] whole = '0, input logic [61:0] fnum = '0,
                          input logic [61:0] fden = '0);
    request_t r;
    r.kind  = k;
    r.na    = IN_BITS'(na);
    r.da    = IN_BITS'(da);
    r.nb    = IN_BITS'(nb);
    r.db    = IN_BITS'(db);
    r.typed = typed;
    r.ans   = '{dbz, neg, whole, fnum, fden};
    directed_requests.push_back(r);
  endtask

  function automatic logic [IN_BITS-1:0] pick_operand();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom_range(0, 200)) - 100;
      4, 5, 6:    v = $urandom;
      7: begin
        case ($urandom_range(0, 4))
          0:       v = OPER_MIN;
          1:       v = OPER_MAX;
          2:       v = 0;
          3:       v = 1;
          default: v = -1;
        endcase
      end
      8: begin
        v = 1 << $urandom_range(0, 29);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    return v[IN_BITS-1:0];
  endfunction

  task automatic send_request(input request_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.kind    = r.kind;
    req.num_a   = r.na;
    req.den_a   = r.da;
    req.num_b   = r.nb;
    req.den_b   = r.db;
    held_typed  = r.typed;
    held_answer = r.ans;
    req.valid   = 1'b1;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  task automatic note_mismatch(input string what, input answer_t want, input answer_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected dbz=%0b neg=%0b whole=%0d num=%0d den=%0d",
               want.dbz, want.neg, want.whole, want.fnum, want.fden);
      $display("  actual   dbz=%0b neg=%0b whole=%0d num=%0d den=%0d",
               got.dbz, got.neg, got.whole, got.fnum, got.fden);
    end
  endtask

  // result check first, then the new request, so both orders within an edge agree
  always @(posedge clk) begin : track_results
    answer_t got, want;
    if (!rst) begin
      if (res.valid && res.ready) begin
        got.dbz   = res.divide_by_zero;
        got.neg   = res.negative;
        got.whole = res.whole_part;
        got.fnum  = res.frac_numerator;
        got.fden  = res.frac_denominator;
        if (pending_answers.size() == 0) begin
          note_mismatch("result with no request outstanding", '0, got);
        end else begin
          want = pending_answers.pop_front();
          if (got.dbz !== want.dbz || got.neg !== want.neg || got.whole !== want.whole ||
              got.fnum !== want.fnum || got.fden !== want.fden)
            note_mismatch("result mismatch", want, got);
        end
      end
      if (req.valid && req.ready)
        pending_answers.push_back(held_typed ? held_answer :
          fraction_result(req.kind, req.num_a, req.den_a, req.num_b, req.den_b));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stall before each result
  initial begin
    int w;
    res.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      w = no_idle ? 0 : $urandom_range(0, 19);
      if (w > 0) begin
        res.ready = 1'b0;
        repeat (w) @(negedge clk);
      end
      res.ready = 1'b1;
      do @(posedge clk); while (!res.valid);
      @(negedge clk);
    end
  end

  initial begin
    request_t r;
    req.valid = 1'b0;
    req.kind  = KIND_ADD;
    req.num_a = '0;
    req.den_a = '0;
    req.num_b = '0;
    req.den_b = '0;

    // typed rows: zero result, zero denominators, extremes
    add_case(KIND_REDUCE, 0, 7, 0, 0, 1'b1, 1'b0, 1'b0, '0, '0, 62'd1);
    add_case(KIND_REDUCE, 5, 0, 3, 4, 1'b1, 1'b1);
    add_case(KIND_ADD, 1, 2, 1, 0, 1'b1, 1'b1);
    add_case(KIND_DIV, 3, 4, 0, 5, 1'b1, 1'b1);
    add_case(KIND_MUL, 2, 0, 3, 4, 1'b1, 1'b1);
    add_case(KIND_SUB, 3, 4, 3, 4, 1'b1, 1'b0, 1'b0, '0, '0, 62'd1);
    add_case(KIND_REDUCE, OPER_MAX, 1, 0, 1, 1'b1, 1'b0, 1'b0, 62'd1073741823, '0, 62'd1);
    add_case(KIND_REDUCE, OPER_MIN, 1, 0, 1, 1'b1, 1'b0, 1'b1, TWO_POW_30, '0, 62'd1);
    add_case(KIND_REDUCE, OPER_MIN, -1, 0, 1, 1'b1, 1'b0, 1'b0, TWO_POW_30, '0, 62'd1);
    add_case(KIND_MUL, OPER_MIN, 1, OPER_MIN, 1, 1'b1, 1'b0, 1'b0, TWO_POW_60, '0, 62'd1);
    add_case(KIND_REDUCE, 6, -4, 0, 1, 1'b1, 1'b0, 1'b1, 62'd1, 62'd1, 62'd2);
    add_case(KIND_REDUCE, 1, OPER_MIN, 0, 1, 1'b1, 1'b0, 1'b1, '0, 62'd1, TWO_POW_30);
    // predicted rows
    add_case(KIND_ADD, 1, 2, 1, 3);
    add_case(KIND_SUB, 1, 2, 3, 4);
    add_case(KIND_MUL, -2, 3, 9, 4);
    add_case(KIND_DIV, 5, 6, -10, 3);
    add_case(KIND_ADD, OPER_MAX, OPER_MIN, OPER_MIN, OPER_MAX);
    add_case(KIND_SUB, OPER_MIN, OPER_MAX, OPER_MAX, OPER_MIN);
    add_case(KIND_MUL, OPER_MAX, OPER_MIN, OPER_MAX, OPER_MIN);
    add_case(KIND_DIV, OPER_MAX, 1, 1, OPER_MIN);
    add_case(KIND_MUL, -1, -1, -1, -1);
    add_case(KIND_SPARE5, 7, 3, 0, 0);
    add_case(KIND_SPARE6, -22, 6, 1, 0);
    add_case(KIND_SPARE7, 9, -12, OPER_MIN, OPER_MAX);

    repeat (2) @(negedge clk);
    rst = 1'b0;

    foreach (directed_requests[i]) send_request(directed_requests[i]);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      // stretches with both sides at full rate
      if (i % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
      r.kind  = KIND_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) :
                                                         $urandom_range(0, 4));
      r.na    = pick_operand();
      r.da    = pick_operand();
      r.nb    = pick_operand();
      r.db    = pick_operand();
      r.typed = 1'b0;
      r.ans   = '0;
      send_request(r);
    end
    req.valid = 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
